/* hw/rtl/internet_checksum_stream_defines.svh */
// ----------------------------------------------------------------------------
// internet_checksum_stream_defines
// Assertion macros for the internet checksum stream block.
// ----------------------------------------------------------------------------
`ifndef INTERNET_CHECKSUM_STREAM_DEFINES_SVH
`define INTERNET_CHECKSUM_STREAM_DEFINES_SVH

`ifndef SYNTH
`define ICS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ICS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ICS_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/icsum_pkg.sv */
// ----------------------------------------------------------------------------
// icsum_pkg
// Types, constants and helpers shared by the checksum stream modules.
// ----------------------------------------------------------------------------
`default_nettype none

package icsum_pkg;

  localparam int unsigned AccW     = 34;
  localparam int unsigned LaneCntW = 4;
  localparam int unsigned AddrW    = 4;

  localparam logic [1:0] RegSkipBytes  = 2'd0;
  localparam logic [1:0] RegSumBytes   = 2'd1;
  localparam logic [1:0] RegInitialSum = 2'd2;

  typedef struct packed {
    logic [31:0] data_bytes;
    logic [2:0]  byte_count;
    logic        end_of_chain;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic        error;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] skip_bytes;
    logic [15:0] sum_bytes;
    logic [31:0] seed_sum;
  } cfg_t;

  typedef struct packed {
    logic [LaneCntW-1:0] first;
    logic [LaneCntW-1:0] count;
    logic                odd;
  } lane_ctrl_t;

  function automatic logic [AccW-1:0] fold17(logic [AccW-1:0] v);
    fold17 = {{(AccW-16){1'b0}}, v[15:0]} + (v >> 16);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/icsum_lane.sv */
// ----------------------------------------------------------------------------
// icsum_lane
// One byte lane: decides whether its byte is summed and at which half.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_lane import icsum_pkg::*; #(
  parameter int unsigned LaneIdx = 0
) (
  input  wire logic [7:0]  byte_i,
  input  wire lane_ctrl_t  ctrl_i,
  output logic      [15:0] word_o
);

  localparam logic [LaneCntW-1:0] Idx = LaneCntW'(LaneIdx);

  logic [LaneCntW-1:0] rel;
  logic                active;

  assign rel    = Idx - ctrl_i.first;
  assign active = (Idx >= ctrl_i.first) && (rel < ctrl_i.count);

  always_comb begin
    word_o = 16'h0000;
    if (active) begin
      if (ctrl_i.odd ^ rel[0]) begin
        word_o = {byte_i, 8'h00};
      end else begin
        word_o = {8'h00, byte_i};
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/icsum_merge.sv */
// ----------------------------------------------------------------------------
// icsum_merge
// Adds the lane words into the running sum and folds the carries once.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_merge import icsum_pkg::*; #(
  parameter int unsigned LANES = 4
) (
  input  wire logic [LANES-1:0][15:0] lane_word_i,
  input  wire logic [AccW-1:0]        acc_i,
  output logic      [AccW-1:0]        acc_o
);

  localparam int unsigned SumW = 16 + $clog2(LANES + 1);

  logic [SumW-1:0] lane_sum;

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_sum = lane_sum + SumW'(lane_word_i[i]);
    end
  end

  assign acc_o = fold17(acc_i + AccW'(lane_sum));

endmodule

`default_nettype wire

/* hw/rtl/icsum_regs.sv */
// ----------------------------------------------------------------------------
// icsum_regs
// APB register file: skip count, sum count and initial sum.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_regs import icsum_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output cfg_t                  cfg_d_o,
  output logic                  restart_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d     = cfg_q;
    restart_o = 1'b0;
    if (wr) begin
      case (idx)
        RegSkipBytes: begin
          cfg_d.skip_bytes = pwdata[15:0];
          restart_o        = 1'b1;
        end
        RegSumBytes: begin
          cfg_d.sum_bytes = pwdata[15:0];
          restart_o       = 1'b1;
        end
        RegInitialSum: begin
          cfg_d.seed_sum = pwdata;
          restart_o      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegSkipBytes:  prdata = {16'h0000, cfg_q.skip_bytes};
      RegSumBytes:   prdata = {16'h0000, cfg_q.sum_bytes};
      RegInitialSum: prdata = cfg_q.seed_sum;
      default:       prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_d_o = cfg_d;

endmodule

`default_nettype wire

/* hw/rtl/internet_checksum_stream.sv */
// ----------------------------------------------------------------------------
// internet_checksum_stream
// Ones' complement 16-bit sum over a packet byte stream, LANES bytes a beat.
//
//   channel   dir   handshake             payload
//   in        in    in_valid_i/in_ready_o in_data_i   (in_beat_t)
//   out       out   out_valid_o/out_ready_i out_data_o (out_beat_t)
//   cfg       in    psel/penable/pwrite   paddr, pwdata, prdata
//
// One beat per cycle unless stalled; the per-beat lane update is combinational.
// A result shows in the cycle after the beat that completes it.
// The output register holds a stalled result; input stalls only while it is full.
// Reset loads the counters from the register reset values; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "internet_checksum_stream_defines.svh"

module internet_checksum_stream import icsum_pkg::*; #(
  parameter int unsigned LANES      = 4,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_beat_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_beat_t             out_data_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  cfg_t                  cfg_d;
  logic                  restart;

  logic [COUNT_BITS-1:0] skip_left_q, skip_left_d;
  logic [COUNT_BITS-1:0] sum_left_q, sum_left_d;
  logic [AccW-1:0]       acc_q, acc_d, acc_next;
  logic                  odd_q, odd_d;
  logic                  given_q, given_d;

  logic                  out_valid_q, out_valid_d;
  logic [AccW-1:0]       out_acc_q, out_acc_d;
  logic                  out_err_q, out_err_d;

  logic                  in_fire;
  logic [LaneCntW-1:0]   n;
  logic [LaneCntW-1:0]   skip_take, rem, sum_take;
  logic [63:0]           data_wide;
  lane_ctrl_t            lane_ctrl;
  logic [LANES-1:0][15:0] lane_word;
  logic [AccW-1:0]       fold_a;
  logic [AccW-1:0]       fold_b;

  icsum_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_d_o   (cfg_d),
    .restart_o (restart)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if ({1'b0, in_data_i.byte_count} > LaneCntW'(LANES)) begin
      n = LaneCntW'(LANES);
    end else begin
      n = {1'b0, in_data_i.byte_count};
    end
    if (skip_left_q < COUNT_BITS'(n)) begin
      skip_take = skip_left_q[LaneCntW-1:0];
    end else begin
      skip_take = n;
    end
    rem = n - skip_take;
    if (sum_left_q < COUNT_BITS'(rem)) begin
      sum_take = sum_left_q[LaneCntW-1:0];
    end else begin
      sum_take = rem;
    end
  end

  assign lane_ctrl.first = skip_take;
  assign lane_ctrl.count = sum_take;
  assign lane_ctrl.odd   = odd_q;
  assign data_wide       = {32'h0000_0000, in_data_i.data_bytes};

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    icsum_lane #(
      .LaneIdx (g)
    ) u_lane (
      .byte_i (data_wide[8*g +: 8]),
      .ctrl_i (lane_ctrl),
      .word_o (lane_word[g])
    );
  end

  icsum_merge #(
    .LANES (LANES)
  ) u_merge (
    .lane_word_i (lane_word),
    .acc_i       (acc_q),
    .acc_o       (acc_next)
  );

  always_comb begin
    skip_left_d = skip_left_q;
    sum_left_d  = sum_left_q;
    acc_d       = acc_q;
    odd_d       = odd_q;
    given_d     = given_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_acc_d   = out_acc_q;
    out_err_d   = out_err_q;
    if (in_fire) begin
      skip_left_d = skip_left_q - COUNT_BITS'(skip_take);
      sum_left_d  = sum_left_q - COUNT_BITS'(sum_take);
      acc_d       = acc_next;
      odd_d       = odd_q ^ sum_take[0];
      if (!given_q && sum_left_d == '0) begin
        out_valid_d = 1'b1;
        out_acc_d   = acc_next;
        out_err_d   = 1'b0;
        given_d     = 1'b1;
      end else if (!given_q && in_data_i.end_of_chain) begin
        out_valid_d = 1'b1;
        out_acc_d   = '0;
        out_err_d   = 1'b1;
      end
    end
    if (restart || (in_fire && in_data_i.end_of_chain)) begin
      skip_left_d = COUNT_BITS'(cfg_d.skip_bytes);
      sum_left_d  = COUNT_BITS'(cfg_d.sum_bytes);
      acc_d       = AccW'(cfg_d.seed_sum);
      odd_d       = 1'b0;
      given_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_left_q <= '0;
      sum_left_q  <= '0;
      acc_q       <= '0;
      odd_q       <= 1'b0;
      given_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      skip_left_q <= skip_left_d;
      sum_left_q  <= sum_left_d;
      acc_q       <= acc_d;
      odd_q       <= odd_d;
      given_q     <= given_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_acc_q <= out_acc_d;
    out_err_q <= out_err_d;
  end

  // final two carry folds on the held sum
  assign fold_a              = fold17(out_acc_q);
  assign fold_b              = fold17(fold_a);
  assign out_valid_o         = out_valid_q;
  assign out_data_o.checksum = out_err_q ? 16'h0000 : fold_b[15:0];
  assign out_data_o.error    = out_err_q;

  `ICS_ASSERT(a_stall_only_full, clk_i, rst_ni,
              !in_ready_o |-> out_valid_q, "input stalled with empty output")
  `ICS_ASSERT(a_eoc_restarts, clk_i, rst_ni,
              in_fire && in_data_i.end_of_chain |=> !given_q && !odd_q,
              "packet state not restarted after end of chain")
  `ICS_ASSERT(a_count_met_emits, clk_i, rst_ni,
              in_fire && !given_q && sum_left_q == '0 |=> out_valid_q && !out_err_q,
              "count met without a result")

endmodule

`default_nettype wire
